[src/m2sh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2sh_pkg: shared types and constants of the sequence header parser
// Item modes, error codes, header layout constants, the scan table and the
// default quantiser values.
// ----------------------------------------------------------------------------
package m2sh_pkg;

  localparam int MATRIX_ENTRIES = 64;

  localparam logic [31:0] START_CODE = 32'h0000_01B3;
  localparam logic [7:0]  NON_INTRA_DEFAULT = 8'd16;

  typedef enum logic [1:0] {
    MODE_RESTART = 2'd0,
    MODE_BYTE    = 2'd1,
    MODE_READ    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_START_CODE  = 3'd1,
    ERR_ASPECT      = 3'd2,
    ERR_FRAME_RATE  = 3'd3,
    ERR_MARKER      = 3'd4,
    ERR_CONSTRAINED = 3'd5,
    ERR_ZERO_ENTRY  = 3'd6
  } err_e;

  // Scan order: loaded entry i lands at raster position ZIGZAG[i].
  localparam logic [5:0] ZIGZAG [MATRIX_ENTRIES] = '{
     0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
    12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
    35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
    58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
  };

  // Standard intra matrix, raster order.
  localparam logic [7:0] DEFAULT_INTRA [MATRIX_ENTRIES] = '{
     8, 16, 19, 22, 26, 27, 29, 34,
    16, 16, 22, 24, 27, 29, 34, 37,
    19, 22, 26, 27, 29, 34, 34, 38,
    22, 22, 26, 27, 29, 34, 37, 40,
    22, 26, 27, 29, 32, 35, 40, 48,
    26, 27, 29, 32, 35, 40, 48, 58,
    26, 27, 29, 34, 38, 46, 56, 69,
    27, 29, 35, 38, 46, 56, 69, 83
  };

endpackage

[src/m2sh_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m2sh_ram: generic single-write, single-read RAM
// One write port and one registered read port; a read of the address being
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module m2sh_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/mpeg2_sequence_header_parser_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpeg2_sequence_header_parser_unit: MPEG-2 sequence header parser
// Parses the sequence header a byte per transaction, loads the optional
// quantiser matrices and answers matrix reads by raster index.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+--------------------------------------
//  in      | in_valid_i / in_ready_o   | mode, byte_value, which_matrix,
//          |                           | entry_index
//  out     | out_valid_o / out_ready_i | header_done, error_code, sizes, codes,
//          |                           | bit_rate, buffer_size, matrix_value
//
// Every input transaction yields exactly one result transaction. A transaction
// waits in the input stage, where the whole byte is decoded and the matrix RAM
// read data arrives, then moves to the registered result stage; a new
// transaction is taken every cycle while the result is not stalled.
// Reset clears the parse state; the matrix RAM is not cleared, since the
// loaded flags hide it until a full 64-entry load.
// A stalled result holds the input stage; the input stage still takes a
// transaction in the cycle that the result is taken.
module mpeg2_sequence_header_parser_unit
  import m2sh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  byte_value_i,
  input  logic        which_matrix_i,
  input  logic [5:0]  entry_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        header_done_o,
  output logic [2:0]  error_code_o,
  output logic [11:0] horizontal_size_o,
  output logic [11:0] vertical_size_o,
  output logic [3:0]  aspect_code_o,
  output logic [3:0]  frame_rate_code_o,
  output logic [17:0] bit_rate_o,
  output logic [9:0]  buffer_size_o,
  output logic [7:0]  matrix_value_o
);

  localparam int CntW     = $clog2(MATRIX_ENTRIES);
  localparam int RamDepth = 2 * MATRIX_ENTRIES;
  localparam int RamAw    = $clog2(RamDepth);

  // Header byte numbers (counting from the first start code byte) at which
  // a field completes.
  localparam logic [CntW-1:0] HB_START  = CntW'(3);
  localparam logic [CntW-1:0] HB_HSIZE  = CntW'(5);
  localparam logic [CntW-1:0] HB_VSIZE  = CntW'(6);
  localparam logic [CntW-1:0] HB_CODES  = CntW'(7);
  localparam logic [CntW-1:0] HB_RATE   = CntW'(10);
  localparam logic [CntW-1:0] HB_LAST   = CntW'(11);
  localparam logic [CntW-1:0] LAST_ENTRY = CntW'(MATRIX_ENTRIES - 1);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_INTRA,
    PH_NON_INTRA,
    PH_DONE
  } phase_e;

  // Handshake and stage control.
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic in_accept, advance;

  // Input stage payload.
  mode_e      s1_mode_q;
  logic [7:0] s1_byte_q;
  logic       s1_which_q;
  logic [5:0] s1_idx_q;

  // Parse state; the field registers also serve as the result fields.
  phase_e          phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [23:0]     hist_q, hist_d;
  logic [11:0]     hsize_q, hsize_d;
  logic [11:0]     vsize_q, vsize_d;
  logic [3:0]      aspect_q, aspect_d;
  logic [3:0]      frc_q, frc_d;
  logic [17:0]     rate_q, rate_d;
  logic [9:0]      vbv_q, vbv_d;
  logic [1:0]      loaded_q, loaded_d;
  err_e            err_q, err_d;
  logic [7:0]      mval_q, mval_d;

  // Matrix RAM: upper address bit picks the non-intra matrix.
  logic             ram_we;
  logic [RamAw-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;
  logic [7:0]       entry;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  m2sh_ram #(
    .Width(8),
    .Depth(RamDepth)
  ) u_matrix_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (in_accept),
    .raddr_i({which_matrix_i, entry_index_i}),
    .rdata_o(ram_rdata)
  );

  // Intra entries sit one bit late: seven bits from this byte, the top bit
  // from the low bit of the previous byte. Non-intra entries are byte aligned.
  assign entry     = (phase_q == PH_INTRA) ? {hist_q[0], s1_byte_q[7:1]} : s1_byte_q;
  assign ram_wdata = entry;
  assign ram_waddr = {(phase_q == PH_NON_INTRA), ZIGZAG[cnt_q]};

  // Decode one byte per transaction.
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    hist_d   = hist_q;
    hsize_d  = hsize_q;
    vsize_d  = vsize_q;
    aspect_d = aspect_q;
    frc_d    = frc_q;
    rate_d   = rate_q;
    vbv_d    = vbv_q;
    loaded_d = loaded_q;
    err_d    = err_q;
    ram_we   = 1'b0;
    if (advance) begin
      unique case (s1_mode_q)
        MODE_RESTART: begin
          phase_d  = PH_HEADER;
          cnt_d    = '0;
          hist_d   = '0;
          hsize_d  = '0;
          vsize_d  = '0;
          aspect_d = '0;
          frc_d    = '0;
          rate_d   = '0;
          vbv_d    = '0;
          loaded_d = '0;
          err_d    = ERR_NONE;
        end
        MODE_BYTE: begin
          hist_d = {hist_q[15:0], s1_byte_q};
          if (err_q == ERR_NONE) begin
            unique case (phase_q)
              PH_HEADER: begin
                cnt_d = cnt_q + CntW'(1);
                unique case (cnt_q)
                  HB_START: begin
                    if ({hist_q, s1_byte_q} != START_CODE) begin
                      err_d = ERR_START_CODE;
                    end
                  end
                  HB_HSIZE: hsize_d = {hist_q[7:0], s1_byte_q[7:4]};
                  HB_VSIZE: vsize_d = {hist_q[3:0], s1_byte_q};
                  HB_CODES: begin
                    aspect_d = s1_byte_q[7:4];
                    if ((s1_byte_q[7:4] < 4'd1) || (s1_byte_q[7:4] > 4'd4)) begin
                      err_d = ERR_ASPECT;
                    end else begin
                      frc_d = s1_byte_q[3:0];
                      if ((s1_byte_q[3:0] < 4'd1) || (s1_byte_q[3:0] > 4'd8)) begin
                        err_d = ERR_FRAME_RATE;
                      end
                    end
                  end
                  HB_RATE: begin
                    rate_d = {hist_q[15:0], s1_byte_q[7:6]};
                    if (!s1_byte_q[5]) begin
                      err_d = ERR_MARKER;
                    end
                  end
                  HB_LAST: begin
                    vbv_d = {hist_q[4:0], s1_byte_q[7:3]};
                    cnt_d = '0;
                    // Then the constrained flag, load-intra and load-non-intra.
                    if (s1_byte_q[2]) begin
                      err_d = ERR_CONSTRAINED;
                    end else if (s1_byte_q[1]) begin
                      phase_d = PH_INTRA;
                    end else if (s1_byte_q[0]) begin
                      phase_d = PH_NON_INTRA;
                    end else begin
                      phase_d = PH_DONE;
                    end
                  end
                  default: ;
                endcase
              end
              PH_INTRA: begin
                ram_we = 1'b1;
                if (entry == 8'd0) begin
                  err_d = ERR_ZERO_ENTRY;
                end else if (cnt_q == LAST_ENTRY) begin
                  // Low bit of the closing byte is the load-non-intra flag.
                  loaded_d[0] = 1'b1;
                  cnt_d       = '0;
                  phase_d     = s1_byte_q[0] ? PH_NON_INTRA : PH_DONE;
                end else begin
                  cnt_d = cnt_q + CntW'(1);
                end
              end
              PH_NON_INTRA: begin
                ram_we = 1'b1;
                if (entry == 8'd0) begin
                  err_d = ERR_ZERO_ENTRY;
                end else if (cnt_q == LAST_ENTRY) begin
                  loaded_d[1] = 1'b1;
                  cnt_d       = '0;
                  phase_d     = PH_DONE;
                end else begin
                  cnt_d = cnt_q + CntW'(1);
                end
              end
              PH_DONE: ;
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Matrix read: RAM data is valid while the read transaction sits in the
  // input stage; an unloaded matrix reads as its default.
  always_comb begin
    mval_d = 8'd0;
    if (s1_mode_q == MODE_READ) begin
      if (s1_which_q) begin
        mval_d = loaded_q[1] ? ram_rdata : NON_INTRA_DEFAULT;
      end else begin
        mval_d = loaded_q[0] ? ram_rdata : DEFAULT_INTRA[s1_idx_q];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_HEADER;
      cnt_q       <= '0;
      hist_q      <= '0;
      hsize_q     <= '0;
      vsize_q     <= '0;
      aspect_q    <= '0;
      frc_q       <= '0;
      rate_q      <= '0;
      vbv_q       <= '0;
      loaded_q    <= '0;
      err_q       <= ERR_NONE;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      hist_q      <= hist_d;
      hsize_q     <= hsize_d;
      vsize_q     <= vsize_d;
      aspect_q    <= aspect_d;
      frc_q       <= frc_d;
      rate_q      <= rate_d;
      vbv_q       <= vbv_d;
      loaded_q    <= loaded_d;
      err_q       <= err_d;
    end
  end

  // Payload registers: load on accept, hold otherwise; the matrix value loads on advance.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_mode_q  <= mode_e'(mode_i);
      s1_byte_q  <= byte_value_i;
      s1_which_q <= which_matrix_i;
      s1_idx_q   <= entry_index_i;
    end
    if (advance) begin
      mval_q <= mval_d;
    end
  end

  // Parse state only moves when a result is produced, so it always matches
  // the result held in the output stage.
  assign out_valid_o       = out_valid_q;
  assign header_done_o     = (phase_q == PH_DONE) && (err_q == ERR_NONE);
  assign error_code_o      = err_q;
  assign horizontal_size_o = hsize_q;
  assign vertical_size_o   = vsize_q;
  assign aspect_code_o     = aspect_q;
  assign frame_rate_code_o = frc_q;
  assign bit_rate_o        = rate_q;
  assign buffer_size_o     = vbv_q;
  assign matrix_value_o    = mval_q;

endmodule
